// ----- rtl/mie_pkg.sv -----
// Package for the modular inverse block.
// Holds the command and status structs shared by the controller, the datapath and
// the top level, and the modulus value loaded at reset. Depends on nothing.
package mie_pkg;

    localparam logic [63:0] RESET_MODULUS = 64'd998244353;

    // Commands from the controller to the datapath. At most one action bit is
    // active in a cycle. The reduce bit selects the operands for div_init.
    typedef struct packed {
        logic load;
        logic div_init;
        logic reduce;
        logic shift_up;
        logic sub_step;
        logic update;
        logic capture;
    } mie_cmd_t;

    typedef struct packed {
        logic r1_zero;
        logic can_shift;
        logic k_zero;
        logic mod_zero;
    } mie_status_t;

endpackage

// ----- rtl/mie_datapath.sv -----
// Datapath of the modular inverse block: Euclid remainders and coefficients, the
// shift-and-subtract divider with its product accumulator, and the modulus register.
// Depends on mie_pkg for the command and status structs.
module mie_datapath #(
    parameter int DATA_WIDTH = 63
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [DATA_WIDTH-1:0]  cfg_data,
    input  logic [DATA_WIDTH-1:0]  value,
    input  mie_pkg::mie_cmd_t      cmd,
    output mie_pkg::mie_status_t   status,
    output logic [DATA_WIDTH-1:0]  inverse,
    output logic [DATA_WIDTH-1:0]  common_divisor
);
    import mie_pkg::*;

    // Coefficients need one bit more than the operands to carry their sign.
    localparam int CW = DATA_WIDTH + 1;
    localparam int KW = $clog2(CW);

    logic [DATA_WIDTH-1:0] modulus_reg;
    logic [DATA_WIDTH-1:0] r0_reg, r0_next;
    logic [DATA_WIDTH-1:0] r1_reg, r1_next;
    logic [CW-1:0]         s0_reg, s0_next;
    logic [CW-1:0]         s1_reg, s1_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [CW-1:0]         ds_reg, ds_next;
    logic [CW-1:0]         prod_reg, prod_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [DATA_WIDTH-1:0] inverse_reg, inverse_next;
    logic [DATA_WIDTH-1:0] gcd_reg, gcd_next;

    logic [CW-1:0]         mag;
    logic [CW-1:0]         ds_dbl;
    logic                  qbit;
    logic [DATA_WIDTH-1:0] rem_w;
    logic [DATA_WIDTH-1:0] inv_val;

    assign mag    = s0_reg[CW-1] ? ({CW{1'b0}} - s0_reg) : s0_reg;
    assign ds_dbl = {ds_reg[CW-2:0], 1'b0};
    assign qbit   = (rem_reg >= ds_reg);
    assign rem_w  = rem_reg[DATA_WIDTH-1:0];

    // The final remainder is the magnitude of the coefficient modulo m; a negative
    // coefficient folds back as m minus that remainder.
    always_comb
    begin
        if (modulus_reg == '0)
            inv_val = '0;
        else if (s0_reg[CW-1] && (rem_w != '0))
            inv_val = modulus_reg - rem_w;
        else
            inv_val = rem_w;
    end

    assign status.r1_zero   = (r1_reg == '0);
    assign status.can_shift = !ds_reg[CW-1] && (ds_dbl <= rem_reg);
    assign status.k_zero    = (k_reg == '0);
    assign status.mod_zero  = (modulus_reg == '0);

    always_comb
    begin
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        rem_next     = rem_reg;
        ds_next      = ds_reg;
        prod_next    = prod_reg;
        k_next       = k_reg;
        inverse_next = inverse_reg;
        gcd_next     = gcd_reg;
        if (cmd.load)
        begin
            r0_next = value;
            r1_next = modulus_reg;
            s0_next = {{(CW-1){1'b0}}, 1'b1};
            s1_next = '0;
        end
        if (cmd.div_init)
        begin
            rem_next  = cmd.reduce ? mag : {1'b0, r0_reg};
            ds_next   = cmd.reduce ? {1'b0, modulus_reg} : {1'b0, r1_reg};
            prod_next = '0;
            k_next    = '0;
        end
        if (cmd.shift_up)
        begin
            ds_next = ds_dbl;
            k_next  = k_reg + 1'b1;
        end
        // Quotient bits arrive most significant first, so the product q * s1
        // builds up in Horner form alongside the remainder.
        if (cmd.sub_step)
        begin
            if (qbit)
                rem_next = rem_reg - ds_reg;
            prod_next = {prod_reg[CW-2:0], 1'b0} + (qbit ? s1_reg : {CW{1'b0}});
            ds_next   = {1'b0, ds_reg[CW-1:1]};
            k_next    = k_reg - 1'b1;
        end
        if (cmd.update)
        begin
            r0_next = r1_reg;
            r1_next = rem_w;
            s0_next = s1_reg;
            s1_next = s0_reg - prod_reg;
        end
        if (cmd.capture)
        begin
            inverse_next = inv_val;
            gcd_next     = r0_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= RESET_MODULUS[DATA_WIDTH-1:0];
        else if (cfg_write)
            modulus_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        rem_reg     <= rem_next;
        ds_reg      <= ds_next;
        prod_reg    <= prod_next;
        k_reg       <= k_next;
        inverse_reg <= inverse_next;
        gcd_reg     <= gcd_next;
    end

    assign inverse        = inverse_reg;
    assign common_divisor = gcd_reg;

endmodule

// ----- rtl/mie_ctrl.sv -----
// Controller of the modular inverse block: sequences Euclid steps, the divider
// phases and the final reduction, and owns both handshakes.
// Depends on mie_pkg for the command and status structs.
module mie_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  mie_pkg::mie_status_t status,
    output mie_pkg::mie_cmd_t    cmd
);
    import mie_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CHECK     = 4'd1;
    localparam logic [3:0] ST_ALIGN     = 4'd2;
    localparam logic [3:0] ST_DIVIDE    = 4'd3;
    localparam logic [3:0] ST_UPDATE    = 4'd4;
    localparam logic [3:0] ST_RED_INIT  = 4'd5;
    localparam logic [3:0] ST_RED_ALIGN = 4'd6;
    localparam logic [3:0] ST_RED_DIV   = 4'd7;
    localparam logic [3:0] ST_FINISH    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.r1_zero)
                    state_next = ST_RED_INIT;
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (status.can_shift)
                    cmd.shift_up = 1'b1;
                else
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.sub_step = 1'b1;
                if (status.k_zero)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_RED_INIT:
            begin
                // With a zero modulus there is nothing to reduce by.
                if (status.mod_zero)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.div_init = 1'b1;
                    cmd.reduce   = 1'b1;
                    state_next   = ST_RED_ALIGN;
                end
            end
            ST_RED_ALIGN:
            begin
                if (status.can_shift)
                    cmd.shift_up = 1'b1;
                else
                    state_next = ST_RED_DIV;
            end
            ST_RED_DIV:
            begin
                cmd.sub_step = 1'b1;
                if (status.k_zero)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/mod_inverse_ext_euclid.sv -----
// Usage: modular inverse by the extended Euclidean algorithm.
// Input channel (in_valid, in_stall, value): one transfer starts one computation.
// in_stall is high from the cycle after a transfer until the block is idle again.
// Output channel (out_valid, out_stall, inverse, common_divisor): one transfer per
// input, in order. inverse is the Bezout coefficient of value reduced into
// 0..modulus-1; it is the modular inverse when common_divisor is one.
// Configuration: cfg_write with cfg_data writes the modulus; write it only while
// no computation is in flight. Reset loads 998244353 and empties the output.
// Each Euclid step checks the remainder, aligns the divisor, takes one subtract step
// per quotient bit and updates the remainders and coefficients; the final reduction
// runs on the same shared shift-and-subtract divider. The computation begins with
// a load and ends by storing the result.
// One item is in work at a time, so a new transfer is taken in the cycle after the
// result is stored. The result sits in an output register, so the next item is
// accepted while it waits; if the receiver stalls and that register is still full
// when the next result is ready, the block holds that result and keeps in_stall
// high until the register frees up.
// Depends on mie_pkg, mie_ctrl and mie_datapath.
module mod_inverse_ext_euclid #(
    parameter int DATA_WIDTH = 63
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [DATA_WIDTH-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] inverse,
    output logic [DATA_WIDTH-1:0] common_divisor
);
    import mie_pkg::*;

    mie_cmd_t    cmd;
    mie_status_t status;

    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mie_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .value          (value),
        .cmd            (cmd),
        .status         (status),
        .inverse        (inverse),
        .common_divisor (common_divisor)
    );

    // An accepted transfer always starts a computation that blocks the input.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not blocked after a transfer");

    // The controller never issues two datapath actions at once.
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_init, cmd.shift_up, cmd.sub_step,
                  cmd.update, cmd.capture}))
        else $error("conflicting datapath commands");

    // A result is stored only when the output register is free or draining.
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !out_valid || !out_stall)
        else $error("pending result overwritten");

endmodule

// ----- test/testbench.sv -----
// Testbench for mod_inverse_ext_euclid: directed and random values against several moduli.
// A behavioral extended Euclid predictor produces the expected inverse and gcd per transfer.
// Depends on mie_pkg and the mod_inverse_ext_euclid RTL only.
module testbench;

    import mie_pkg::*;

    localparam int W = 63;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int IDLE_SETTLE = 8;
    localparam int END_WAIT = 800;
    localparam int MAX_PRINTED = 40;

    localparam logic [W-1:0] ALL_ONES = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [W-1:0] MERSENNE_61 = 63'd2305843009213693951;
    localparam logic [W-1:0] FIB_91 = 63'd4660046610375530309;
    localparam logic [W-1:0] FIB_92 = 63'd7540113804746346429;

    typedef struct packed {
        logic [W-1:0] inverse;
        logic [W-1:0] divisor;
    } inverse_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_write = 1'b0;
    logic [W-1:0] cfg_data = '0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [W-1:0] value = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] inverse;
    logic [W-1:0] common_divisor;

    inverse_result_t pending_results[$];
    inverse_result_t result_due;
    logic [W-1:0]    modulus_copy = W'(RESET_MODULUS);
    int              error_count = 0;
    int              cycle_count = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              hold_request = 0;
    int              hold_left = 0;

    mod_inverse_ext_euclid #(
        .DATA_WIDTH(W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .inverse(inverse),
        .common_divisor(common_divisor)
    );

    always #10 clk = ~clk;

    // Coefficients are kept in 64 bits and allowed to wrap; their true values fit in a
    // signed 64-bit range, so the sign bit tells which way to reduce.
    function automatic inverse_result_t predict_inverse(logic [W-1:0] a, logic [W-1:0] m);
        logic [63:0] r0, r1, s0, s1, q, rn, sn, mag, rem;
        inverse_result_t res;
        r0 = 64'(a);
        r1 = 64'(m);
        s0 = 64'd1;
        s1 = 64'd0;
        while (r1 != 64'd0)
        begin
            q = r0 / r1;
            rn = r0 - q * r1;
            sn = s0 - q * s1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
        end
        res.divisor = r0[W-1:0];
        if (m == '0)
            res.inverse = '0;
        else if (s0[63])
        begin
            mag = 64'd0 - s0;
            rem = mag % 64'(m);
            res.inverse = (rem == 64'd0) ? '0 : W'(64'(m) - rem);
        end
        else
            res.inverse = W'(s0 % 64'(m));
        return res;
    endfunction

    function automatic logic [W-1:0] rand_word();
        return W'({$urandom, $urandom});
    endfunction

    function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
        case ($urandom_range(9))
            0, 1: return W'($urandom_range(20, 0));
            2: return m - W'($urandom_range(3, 0));
            3: return m * W'($urandom_range(3, 1));
            4: return rand_word() >> $urandom_range(62, 0);
            default: return rand_word();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        if (error_count < MAX_PRINTED)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Offers one value, holds it until the transfer, then records its expected result.
    task automatic send_value(input logic [W-1:0] v);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(600, 1) : $urandom_range(6, 1);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_inverse(v, modulus_copy));
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic set_modulus(input logic [W-1:0] m);
        settle_idle();
        cfg_write <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        modulus_copy = m;
    endtask

    task automatic run_random_items(input int count, input int idle_pct, input int stall_pct,
                                    input logic [W-1:0] m);
        set_modulus(m);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_value(pick_value(m));
    endtask

    // Runs with the modulus loaded by reset, so the reset value is checked too.
    task automatic test_reset_modulus();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_value('0);
        send_value(W'(1));
        send_value(W'(2));
        send_value(W'(998244352));
        send_value(W'(998244353));
        send_value(W'(64'd998244353 * 2 + 5));
        send_value(ALL_ONES);
    endtask

    task automatic test_large_moduli();
        set_modulus(ALL_ONES);
        send_value(W'(1));
        send_value(ALL_ONES - W'(1));
        send_value(63'h4000_0000_0000_0000);
        // Consecutive Fibonacci numbers give the longest chain of Euclid steps.
        set_modulus(FIB_92);
        send_value(FIB_91);
        send_value(FIB_92 - W'(1));
        set_modulus(MERSENNE_61);
        send_value(W'(12345));
        set_modulus(63'h4000_0000_0000_0000);
        send_value(W'(6));
        send_value('0);
    endtask

    task automatic test_degenerate_moduli();
        set_modulus(W'(2));
        send_value(W'(1));
        send_value(ALL_ONES);
        set_modulus(W'(1));
        send_value('0);
        send_value(W'(9));
        // A zero modulus allows no reduction: the gcd is the value itself.
        set_modulus('0);
        send_value('0);
        send_value(W'(7));
        send_value(ALL_ONES);
    endtask

    task automatic test_random_traffic();
        logic [W-1:0] m;
        m = rand_word();
        if (m < W'(2))
            m = W'(2);
        run_random_items(65, 0, 0, m);
        run_random_items(65, 76, 0, MERSENNE_61);
        run_random_items(65, 0, 76, W'($urandom_range(1000, 2)));
        m = rand_word() & ~W'(15);
        if (m == '0)
            m = W'(16);
        run_random_items(65, 12, 12, m);
    endtask

    // The receiver refuses results for a long stretch while values keep coming, so
    // the output register fills and the block has to stall its input.
    task automatic test_output_holdoff();
        set_modulus(MERSENNE_61);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1500;
        repeat (8) send_value(rand_word());
    endtask

    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, inverse", inverse, '0);
            else
            begin
                result_due = pending_results.pop_front();
                if (inverse !== result_due.inverse)
                    report_mismatch("inverse", inverse, result_due.inverse);
                if (common_divisor !== result_due.divisor)
                    report_mismatch("common_divisor", common_divisor, result_due.divisor);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_large_moduli();
        test_degenerate_moduli();
        test_random_traffic();
        test_output_holdoff();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
